FILE: hw/rtl/bsg_pkg.sv
// Shared types, widths, codes and constants of the battery guard supervisor.
package bsg_pkg;

  localparam int V_W        = 14;
  localparam int T_W        = 32;
  localparam int MARGIN_W   = 12;
  localparam int RATE_W     = 10;
  localparam int CMD_W      = 3;
  localparam int MODE_W     = 2;
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;

  localparam int unsigned DEF_MIN_CEILING_MV = 10000;
  localparam int unsigned DEF_DECAY_GAP_MS   = 100;

  // Decay step: floor(rate * dt / 1000), saturated once it exceeds any sample.
  localparam int PROD_W      = RATE_W + T_W;
  localparam int QUOT_W      = V_W + 1;
  localparam int MS_PER_S    = 1000;
  localparam int RECIP_IN_W  = 24;
  localparam int RECIP_MUL_W = 25;
  localparam int RECIP_SHIFT = 34;
  localparam int RECIP_W     = RECIP_IN_W + RECIP_MUL_W;
  localparam logic [63:0] RECIP_FULL =
      ((64'd1 << RECIP_SHIFT) + 64'(MS_PER_S) - 64'd1) / 64'(MS_PER_S);
  localparam logic [RECIP_MUL_W-1:0] RECIP_MUL = RECIP_FULL[RECIP_MUL_W-1:0];
  localparam logic [PROD_W-1:0] QUOT_LIMIT = PROD_W'((64'd1 << V_W) * 64'(MS_PER_S));
  localparam logic [QUOT_W-1:0] QUOT_SAT = QUOT_W'(64'd1 << V_W);

  localparam logic [0:0]          DEF_MONITOR_ENABLE   = 1'b1;
  localparam logic [V_W-1:0]      DEF_CRITICAL_MV      = 14'd6400;
  localparam logic [MARGIN_W-1:0] DEF_NEAR_MARGIN_MV   = 12'd300;
  localparam logic [V_W-1:0]      DEF_WARNING_MV       = 14'd7000;
  localparam logic [RATE_W-1:0]   DEF_DECAY_RATE       = 10'd10;
  localparam logic [T_W-1:0]      DEF_CRITICAL_COOLDOWN = 32'd5000;
  localparam logic [T_W-1:0]      DEF_WARNING_COOLDOWN  = 32'd10000;

  localparam logic REASON_OPERATOR = 1'b0;
  localparam logic REASON_BATTERY  = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_UPDATE         = 3'd0,
    CMD_SET_INPUT_LOSS = 3'd1,
    CMD_SET_LINK_LOSS  = 3'd2,
    CMD_ESTOP          = 3'd3,
    CMD_CLEAR_ESTOP    = 3'd4,
    CMD_RESET_MIN      = 3'd5
  } cmd_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR      = 2'd0,
    MODE_ESTOP      = 2'd1,
    MODE_LINK_LOSS  = 2'd2,
    MODE_INPUT_LOSS = 2'd3
  } mode_t;

  typedef enum logic [ADDR_W-3:0] {
    REG_MONITOR_ENABLE    = 3'd0,
    REG_CRITICAL_MV       = 3'd1,
    REG_NEAR_MARGIN_MV    = 3'd2,
    REG_WARNING_MV        = 3'd3,
    REG_DECAY_RATE        = 3'd4,
    REG_CRITICAL_COOLDOWN = 3'd5,
    REG_WARNING_COOLDOWN  = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic                monitor_enable;
    logic [V_W-1:0]      critical_mv;
    logic [MARGIN_W-1:0] near_margin_mv;
    logic [V_W-1:0]      warning_mv;
    logic [RATE_W-1:0]   decay_rate_mv_per_s;
    logic [T_W-1:0]      critical_cooldown_ms;
    logic [T_W-1:0]      warning_cooldown_ms;
  } cfg_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             flag_value;
    logic [V_W-1:0]   voltage_mv;
    logic [T_W-1:0]   now_ms;
    logic             external_fault;
  } item_t;

  typedef struct packed {
    item_t             item;
    logic              gap;
    logic [QUOT_W-1:0] quot;
  } stage_t;

endpackage

FILE: hw/rtl/bsg_if.sv
// Item channel interfaces for the battery guard supervisor.
interface bsg_req_if;
  import bsg_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CMD_W-1:0]     cmd;
  logic                 flag_value;
  logic [V_W-1:0]       voltage_mv;
  logic [T_W-1:0]       now_ms;
  logic                 external_fault;

  modport source (output valid, cmd, flag_value, voltage_mv, now_ms, external_fault,
                  input ready);
  modport sink (input valid, cmd, flag_value, voltage_mv, now_ms, external_fault,
                output ready);
endinterface

interface bsg_rsp_if;
  import bsg_pkg::*;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] safety_state;
  logic [V_W-1:0]    min_voltage_mv;
  logic              fault_trigger;
  logic              fault_reason;
  logic              near_critical_warn;
  logic              low_battery_warn;

  modport source (output valid, safety_state, min_voltage_mv, fault_trigger, fault_reason,
                  near_critical_warn, low_battery_warn, input ready);
  modport sink (input valid, safety_state, min_voltage_mv, fault_trigger, fault_reason,
                near_critical_warn, low_battery_warn, output ready);
endinterface

FILE: hw/rtl/bsg_cfg.sv
// Configuration register file with its APB-style access port.
module bsg_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bsg_pkg::ADDR_W-1:0]  paddr,
  input  logic [bsg_pkg::DATA_W-1:0]  pwdata,
  output logic [bsg_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output bsg_pkg::cfg_t               cfg
);
  import bsg_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.monitor_enable       <= DEF_MONITOR_ENABLE;
      cfg.critical_mv          <= DEF_CRITICAL_MV;
      cfg.near_margin_mv       <= DEF_NEAR_MARGIN_MV;
      cfg.warning_mv           <= DEF_WARNING_MV;
      cfg.decay_rate_mv_per_s  <= DEF_DECAY_RATE;
      cfg.critical_cooldown_ms <= DEF_CRITICAL_COOLDOWN;
      cfg.warning_cooldown_ms  <= DEF_WARNING_COOLDOWN;
    end else if (wr) begin
      unique case (idx)
        REG_MONITOR_ENABLE:    cfg.monitor_enable       <= pwdata[0];
        REG_CRITICAL_MV:       cfg.critical_mv          <= pwdata[V_W-1:0];
        REG_NEAR_MARGIN_MV:    cfg.near_margin_mv       <= pwdata[MARGIN_W-1:0];
        REG_WARNING_MV:        cfg.warning_mv           <= pwdata[V_W-1:0];
        REG_DECAY_RATE:        cfg.decay_rate_mv_per_s  <= pwdata[RATE_W-1:0];
        REG_CRITICAL_COOLDOWN: cfg.critical_cooldown_ms <= pwdata[T_W-1:0];
        REG_WARNING_COOLDOWN:  cfg.warning_cooldown_ms  <= pwdata[T_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_MONITOR_ENABLE:    prdata = DATA_W'(cfg.monitor_enable);
      REG_CRITICAL_MV:       prdata = DATA_W'(cfg.critical_mv);
      REG_NEAR_MARGIN_MV:    prdata = DATA_W'(cfg.near_margin_mv);
      REG_WARNING_MV:        prdata = DATA_W'(cfg.warning_mv);
      REG_DECAY_RATE:        prdata = DATA_W'(cfg.decay_rate_mv_per_s);
      REG_CRITICAL_COOLDOWN: prdata = cfg.critical_cooldown_ms;
      REG_WARNING_COOLDOWN:  prdata = cfg.warning_cooldown_ms;
      default:               prdata = '0;
    endcase
  end

endmodule

FILE: hw/rtl/bsg_decay.sv
// Front pipeline: elapsed time, decay product and divide by 1000 per item.
module bsg_decay #(
  parameter int unsigned DECAY_GAP_MS = bsg_pkg::DEF_DECAY_GAP_MS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  bsg_pkg::cfg_t                   cfg,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  bsg_pkg::item_t                  in_item,
  output logic                            out_valid,
  input  logic                            out_ready,
  output bsg_pkg::stage_t                 out_data
);
  import bsg_pkg::*;

  logic [T_W-1:0]         last_decay_ms;
  logic                   a_valid;
  item_t                  a_item;
  logic [T_W-1:0]         a_dt;
  logic                   b_valid;
  item_t                  b_item;
  logic                   b_gap;
  logic [PROD_W-1:0]      b_prod;
  logic                   c_valid;
  stage_t                 c_data;
  logic                   en_a;
  logic                   en_b;
  logic                   en_c;
  logic [RECIP_W-1:0]     recip;
  logic [QUOT_W-1:0]      quot;

  assign en_c     = !c_valid || out_ready;
  assign en_b     = !b_valid || en_c;
  assign en_a     = !a_valid || en_b;
  assign in_ready = en_a;

  assign out_valid = c_valid;
  assign out_data  = c_data;

  always_comb begin
    recip = RECIP_W'(b_prod[RECIP_IN_W-1:0]) * RECIP_W'(RECIP_MUL);
    if (b_prod >= QUOT_LIMIT) begin
      quot = QUOT_SAT;
    end else begin
      quot = recip[RECIP_SHIFT +: QUOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_decay_ms <= '0;
      a_valid       <= 1'b0;
      b_valid       <= 1'b0;
      c_valid       <= 1'b0;
    end else begin
      if (en_a) a_valid <= in_valid;
      if (en_b) b_valid <= a_valid;
      if (en_c) c_valid <= b_valid;
      if (in_valid && en_a && cmd_t'(in_item.cmd) == CMD_UPDATE && cfg.monitor_enable) begin
        last_decay_ms <= in_item.now_ms;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      a_item <= in_item;
      a_dt   <= in_item.now_ms - last_decay_ms;
    end
    if (en_b) begin
      b_item <= a_item;
      b_gap  <= a_dt > T_W'(DECAY_GAP_MS);
      b_prod <= PROD_W'(cfg.decay_rate_mv_per_s) * PROD_W'(a_dt);
    end
    if (en_c) begin
      c_data.item <= b_item;
      c_data.gap  <= b_gap;
      c_data.quot <= quot;
    end
  end

endmodule

FILE: hw/rtl/bsg_track.sv
// Supervisor state, minimum tracking, fault and warning logic, result register.
module bsg_track #(
  parameter int unsigned MIN_CEILING_MV = bsg_pkg::DEF_MIN_CEILING_MV
) (
  input  logic            clk,
  input  logic            rst,
  input  bsg_pkg::cfg_t   cfg,
  input  logic            s_valid,
  output logic            s_ready,
  input  bsg_pkg::stage_t s_data,
  bsg_rsp_if.source       rsp
);
  import bsg_pkg::*;

  mode_t               mode;
  mode_t               mode_next;
  logic                input_loss;
  logic                input_loss_next;
  logic                link_loss;
  logic                link_loss_next;
  logic                estop;
  logic                estop_next;
  logic                fault;
  logic                fault_next;
  logic [V_W-1:0]      tracked;
  logic [V_W-1:0]      tracked_next;
  logic [T_W-1:0]      last_warn;
  logic [T_W-1:0]      last_warn_next;
  logic [T_W-1:0]      last_crit;
  logic [T_W-1:0]      last_crit_next;
  logic                stop;
  logic                trig;
  logic                reason;
  logic                near_w;
  logic                low_w;
  logic [QUOT_W-1:0]   capped;
  logic [V_W-1:0]      decayed;
  logic [V_W-1:0]      lowered;
  logic [QUOT_W-1:0]   near_level;
  logic [T_W-1:0]      crit_wait;
  logic [T_W-1:0]      warn_wait;
  logic                take;
  logic [V_W-1:0]      v;
  logic [T_W-1:0]      now;

  logic                o_valid;
  mode_t               o_state;
  logic [V_W-1:0]      o_min;
  logic                o_trig;
  logic                o_reason;
  logic                o_near;
  logic                o_low;

  assign s_ready = !o_valid || rsp.ready;
  assign take    = s_valid && s_ready;
  assign v       = s_data.item.voltage_mv;
  assign now     = s_data.item.now_ms;

  assign rsp.valid              = o_valid;
  assign rsp.safety_state       = o_state;
  assign rsp.min_voltage_mv     = o_min;
  assign rsp.fault_trigger      = o_trig;
  assign rsp.fault_reason       = o_reason;
  assign rsp.near_critical_warn = o_near;
  assign rsp.low_battery_warn   = o_low;

  always_comb begin
    capped = QUOT_W'(tracked) + s_data.quot;
    if (capped > QUOT_W'(v)) capped = QUOT_W'(v);
    if (capped > QUOT_W'(MIN_CEILING_MV)) capped = QUOT_W'(MIN_CEILING_MV);
    decayed    = s_data.gap ? capped[V_W-1:0] : tracked;
    lowered    = (v < decayed) ? v : decayed;
    near_level = QUOT_W'(cfg.critical_mv) + QUOT_W'(cfg.near_margin_mv);
    crit_wait  = now - last_crit;
    warn_wait  = now - last_warn;

    stop            = estop || fault || s_data.item.external_fault;
    mode_next       = mode;
    input_loss_next = input_loss;
    link_loss_next  = link_loss;
    estop_next      = estop;
    fault_next      = fault;
    tracked_next    = tracked;
    last_warn_next  = last_warn;
    last_crit_next  = last_crit;
    trig            = 1'b0;
    reason          = REASON_OPERATOR;
    near_w          = 1'b0;
    low_w           = 1'b0;

    unique case (cmd_t'(s_data.item.cmd))
      CMD_UPDATE: begin
        if (cfg.monitor_enable) begin
          tracked_next = lowered;
          if (lowered < cfg.critical_mv && !stop) begin
            stop       = 1'b1;
            fault_next = 1'b1;
            trig       = 1'b1;
            reason     = REASON_BATTERY;
          end else if (QUOT_W'(v) < near_level) begin
            if (crit_wait >= cfg.critical_cooldown_ms) begin
              near_w         = 1'b1;
              last_crit_next = now;
            end
          end else if (v < cfg.warning_mv) begin
            if (warn_wait >= cfg.warning_cooldown_ms) begin
              low_w          = 1'b1;
              last_warn_next = now;
            end
          end
        end
        priority if (stop) begin
          mode_next = MODE_ESTOP;
        end else if (link_loss) begin
          mode_next = MODE_LINK_LOSS;
        end else if (input_loss) begin
          mode_next = MODE_INPUT_LOSS;
        end else begin
          mode_next = MODE_CLEAR;
        end
      end
      CMD_SET_INPUT_LOSS: input_loss_next = s_data.item.flag_value;
      CMD_SET_LINK_LOSS:  link_loss_next  = s_data.item.flag_value;
      CMD_ESTOP: begin
        estop_next = 1'b1;
        fault_next = 1'b1;
        trig       = 1'b1;
        reason     = REASON_OPERATOR;
      end
      CMD_CLEAR_ESTOP: begin
        estop_next   = 1'b0;
        fault_next   = 1'b0;
        tracked_next = V_W'(MIN_CEILING_MV);
      end
      CMD_RESET_MIN: tracked_next = V_W'(MIN_CEILING_MV);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_CLEAR;
      input_loss <= 1'b0;
      link_loss  <= 1'b0;
      estop      <= 1'b0;
      fault      <= 1'b0;
      tracked    <= V_W'(MIN_CEILING_MV);
      last_warn  <= '0;
      last_crit  <= '0;
      o_valid    <= 1'b0;
    end else begin
      if (s_ready) o_valid <= s_valid;
      if (take) begin
        mode       <= mode_next;
        input_loss <= input_loss_next;
        link_loss  <= link_loss_next;
        estop      <= estop_next;
        fault      <= fault_next;
        tracked    <= tracked_next;
        last_warn  <= last_warn_next;
        last_crit  <= last_crit_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      o_state  <= mode_next;
      o_min    <= tracked_next;
      o_trig   <= trig;
      o_reason <= reason;
      o_near   <= near_w;
      o_low    <= low_w;
    end
  end

endmodule

FILE: hw/rtl/safety_supervisor_battery_guard_core.sv
// Top level of the battery guard safety supervisor.
// Items pass pipeline stages a, b and c, then the result register; the decay multiply and
// the divide by 1000 run in two pipeline stages, and state is updated in the single stage
// before the result register. Throughput: one item per cycle unless the result side stalls.
// Stalls on the result side fill empty stages before input ready drops.
// Reset is synchronous: state, timers and configuration return to their defaults.
module safety_supervisor_battery_guard_core #(
  parameter int unsigned MIN_CEILING_MV = bsg_pkg::DEF_MIN_CEILING_MV,
  parameter int unsigned DECAY_GAP_MS   = bsg_pkg::DEF_DECAY_GAP_MS
) (
  input  logic                        clk,
  input  logic                        rst,
  bsg_req_if.sink                     req,
  bsg_rsp_if.source                   rsp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bsg_pkg::ADDR_W-1:0]  paddr,
  input  logic [bsg_pkg::DATA_W-1:0]  pwdata,
  output logic [bsg_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import bsg_pkg::*;

  cfg_t   cfg;
  item_t  in_item;
  logic   s_valid;
  logic   s_ready;
  stage_t s_data;

  assign in_item.cmd            = req.cmd;
  assign in_item.flag_value     = req.flag_value;
  assign in_item.voltage_mv     = req.voltage_mv;
  assign in_item.now_ms         = req.now_ms;
  assign in_item.external_fault = req.external_fault;

  bsg_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bsg_decay #(
    .DECAY_GAP_MS (DECAY_GAP_MS)
  ) u_decay (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .in_item   (in_item),
    .out_valid (s_valid),
    .out_ready (s_ready),
    .out_data  (s_data)
  );

  bsg_track #(
    .MIN_CEILING_MV (MIN_CEILING_MV)
  ) u_track (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .rsp     (rsp)
  );

endmodule
